[design/fdlp_pkg.sv]
// ----------------------------------------------------------------------------
// fdlp_pkg
// shared types and constants for the long-period pwm fan drive core
// ----------------------------------------------------------------------------
package fdlp_pkg;

	// long pulse train length in control periods
	localparam int PERIOD_STEPS_DEF = 10;

	// field widths
	localparam int PCT_W   = 7;
	localparam int LVL_W   = 8;
	localparam int PROD_W  = 15;
	localparam int IDX_W   = 3;
	localparam int TDATA_W = 16;
	localparam int CNT_W   = 4;
	localparam int DIV_STEPS = PROD_W;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ACTIVE_FLOOR = 3'd0;
	localparam logic [IDX_W-1:0] REG_CUR_MAX      = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_SPEED    = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_SPEED    = 3'd3;
	localparam logic [IDX_W-1:0] REG_INVERT       = 3'd4;
	localparam logic [IDX_W-1:0] REG_FEEDVOLT     = 3'd5;

	// percent limits and reset values
	localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
	localparam logic [PCT_W-1:0] FLOOR_MAX     = 7'd99;
	localparam logic [PCT_W-1:0] MIN_SPEED_RST = 7'd10;

	// blower target mapping
	localparam logic [LVL_W-1:0] TGT_FULL     = 8'd255;
	localparam logic [LVL_W-1:0] TGT_FV_LOW   = 8'd94;
	localparam logic [LVL_W-1:0] TGT_FV_SPAN  = 8'd135;
	localparam logic [LVL_W-1:0] BOOST_DUTY   = 8'd255;
	localparam logic [LVL_W-1:0] BOOST_PRESET = 8'd128;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESCALE,
		ST_DIV,
		ST_PULSE,
		ST_GATE,
		ST_INVERT,
		ST_SCALE,
		ST_TARGET,
		ST_TRIM,
		ST_DONE
	} state_t;

	// which step consumes the divider quotient
	typedef enum logic [1:0] {
		PH_RESCALE,
		PH_PULSE,
		PH_TARGET
	} phase_t;

endpackage

[design/fan_drive_long_pwm_feedback_core.sv]
// ----------------------------------------------------------------------------
// fan_drive_long_pwm_feedback_core
// fan output stage: percent rescale, long-period pulsing, invert, blower
// target mapping, kick start and feedback voltage trim of the drive level
// ----------------------------------------------------------------------------
// Usage
//   s_* stream: one transaction per control request. s_tuser is the request
//   type (1 full-period commit, 0 sub-period feedback trim), s_tdata carries
//   the controller percent and the feedback reading.
//   m_* stream: one transaction per request with duty and fan speed in
//   m_tdata and the kick start flag in m_tuser.
//   cfg_* channel: register writes, index 0..5, always ready; write only
//   while no request is in flight. Other indexes are dropped.
// Sequencing
//   a sub-period trim goes straight to the trim step. A commit runs the
//   shared 15-step restoring divider one to three times: for the rescale,
//   again in the long pulse range, and for the target unless the speed
//   ends at 0; a kick start skips the trim. s_tready returns as the result
//   shows; one request is worked at a time, s_tready is high only while idle.
// Reset and stall
//   arst_n clears the control state and loads the register reset values. A result
//   not taken sits in the output register; the next request is still taken
//   and waits in its last step until the output register frees up.
// ----------------------------------------------------------------------------
module fan_drive_long_pwm_feedback_core #(
	parameter int PERIOD_STEPS = fdlp_pkg::PERIOD_STEPS_DEF // 2..200
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fdlp_pkg::TDATA_W-1:0]  s_tdata,  // pid_percent[6:0], feedback_level[14:7]
	input  logic                          s_tuser,  // req_type
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fdlp_pkg::TDATA_W-1:0]  m_tdata,  // pwm_duty[7:0], fan_speed[14:8]
	output logic                          m_tuser,  // boost
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fdlp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fdlp_pkg::PCT_W-1:0]    cfg_data
);

	localparam int PCT_W  = fdlp_pkg::PCT_W;
	localparam int LVL_W  = fdlp_pkg::LVL_W;
	localparam int PROD_W = fdlp_pkg::PROD_W;
	localparam int CNT_W  = fdlp_pkg::CNT_W;
	localparam logic [LVL_W-1:0] STEPS_LAST = LVL_W'(PERIOD_STEPS - 1);

	fdlp_pkg::state_t state_q, state_d;
	fdlp_pkg::phase_t phase_q;

	// configuration registers
	logic [PCT_W-1:0] floor_q, cmax_q, mins_q, maxs_q;
	logic             invert_q, feedvolt_q;

	// request and block state
	logic [PCT_W-1:0] pct_q, spd_q, last_speed_q;
	logic [LVL_W-1:0] fb_q, timer_q, target_q, drive_q, duty_q;
	logic             boost_q, kick_q;

	// divider registers
	logic [PROD_W-1:0] quo_q;
	logic [PCT_W-1:0]  rem_q, den_q;
	logic [CNT_W-1:0]  cnt_q;

	// output register
	logic                         m_tvalid_q, m_tuser_q;
	logic [fdlp_pkg::TDATA_W-1:0] m_tdata_q;

	// control from the sequencer
	logic              div_load;
	logic [LVL_W-1:0]  mul_a;
	logic [PCT_W-1:0]  mul_b, den_d;
	logic [PROD_W-1:0] product;

	// saturated register views
	logic [PCT_W-1:0] floor_sat, cmax_sat, mins_sat, maxs_sat, pct_excess, quo7, spd_inv;
	logic             out_free, div_last;

	assign floor_sat = (floor_q > fdlp_pkg::FLOOR_MAX) ? fdlp_pkg::FLOOR_MAX : floor_q;
	assign cmax_sat  = (cmax_q > fdlp_pkg::PCT_FULL) ? fdlp_pkg::PCT_FULL : cmax_q;
	assign mins_sat  = (mins_q > fdlp_pkg::PCT_FULL) ? fdlp_pkg::PCT_FULL : mins_q;
	assign maxs_sat  = (maxs_q > fdlp_pkg::PCT_FULL) ? fdlp_pkg::PCT_FULL : maxs_q;
	assign pct_excess = (pct_q >= floor_sat) ? (pct_q - floor_sat) : '0;
	assign quo7      = quo_q[PCT_W-1:0];
	assign spd_inv   = invert_q ? ((maxs_sat > spd_q) ? (maxs_sat - spd_q) : '0) : spd_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign div_last  = (cnt_q == CNT_W'(fdlp_pkg::DIV_STEPS - 1));

	// shared multiplier feeding the divider numerator
	assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

	// divider step: shift in one numerator bit, subtract when it fits
	logic [PCT_W:0]   trial;
	logic             fits;
	logic [PCT_W-1:0] rem_next;
	always_comb begin
		trial    = {rem_q, quo_q[PROD_W-1]};
		fits     = (trial >= {1'b0, den_q});
		rem_next = fits ? PCT_W'(trial - {1'b0, den_q}) : trial[PCT_W-1:0];
	end

	// trim: drive + (target - fb)/2 toward 0, clamp 1..255, if feedvolt and target != 0
	logic signed [LVL_W+1:0] err, half, nv;
	logic [LVL_W-1:0]        trim_lvl;
	always_comb begin
		err  = $signed({2'b00, target_q}) - $signed({2'b00, fb_q});
		half = (err + ((err < 0) ? 10'sd1 : 10'sd0)) >>> 1;
		nv   = $signed({2'b00, drive_q}) + half;
		if (target_q == '0 || !feedvolt_q) begin
			trim_lvl = target_q;
		end else if (nv < 10'sd1) begin
			trim_lvl = LVL_W'(1);
		end else if (nv > 10'sd255) begin
			trim_lvl = fdlp_pkg::TGT_FULL;
		end else begin
			trim_lvl = nv[LVL_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fdlp_pkg::ST_IDLE:
				if (s_tvalid) state_d = s_tuser ? fdlp_pkg::ST_RESCALE : fdlp_pkg::ST_TRIM;
			fdlp_pkg::ST_RESCALE: state_d = fdlp_pkg::ST_DIV;
			fdlp_pkg::ST_DIV: begin
				if (div_last) begin
					unique case (phase_q)
						fdlp_pkg::PH_RESCALE: state_d = fdlp_pkg::ST_PULSE;
						fdlp_pkg::PH_PULSE:   state_d = fdlp_pkg::ST_GATE;
						default:              state_d = fdlp_pkg::ST_TARGET;
					endcase
				end
			end
			fdlp_pkg::ST_PULSE:
				state_d = (quo7 < mins_sat) ? fdlp_pkg::ST_DIV : fdlp_pkg::ST_INVERT;
			fdlp_pkg::ST_GATE:   state_d = fdlp_pkg::ST_INVERT;
			fdlp_pkg::ST_INVERT: state_d = fdlp_pkg::ST_SCALE;
			fdlp_pkg::ST_SCALE:
				state_d = (spd_q == '0) ? fdlp_pkg::ST_TRIM : fdlp_pkg::ST_DIV;
			fdlp_pkg::ST_TARGET:
				state_d = kick_q ? fdlp_pkg::ST_DONE : fdlp_pkg::ST_TRIM;
			fdlp_pkg::ST_TRIM:   state_d = fdlp_pkg::ST_DONE;
			fdlp_pkg::ST_DONE:
				if (out_free) state_d = fdlp_pkg::ST_IDLE;
			default: state_d = fdlp_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and divider load
	always_comb begin
		s_tready = (state_q == fdlp_pkg::ST_IDLE);
		div_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		den_d    = fdlp_pkg::PCT_FULL;
		unique case (state_q)
			fdlp_pkg::ST_RESCALE: begin
				div_load = 1'b1;
				mul_a    = {1'b0, pct_excess};
				mul_b    = cmax_sat;
				den_d    = fdlp_pkg::PCT_FULL - floor_sat;
			end
			fdlp_pkg::ST_PULSE: begin
				div_load = (quo7 < mins_sat);
				mul_a    = LVL_W'(PERIOD_STEPS);
				mul_b    = quo7;
				den_d    = mins_sat;
			end
			fdlp_pkg::ST_SCALE: begin
				div_load = (spd_q != '0);
				mul_a    = feedvolt_q ? fdlp_pkg::TGT_FV_SPAN : fdlp_pkg::TGT_FULL;
				mul_b    = spd_q;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdlp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q    <= '0;
			cmax_q     <= fdlp_pkg::PCT_FULL;
			mins_q     <= fdlp_pkg::MIN_SPEED_RST;
			maxs_q     <= fdlp_pkg::PCT_FULL;
			invert_q   <= 1'b0;
			feedvolt_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fdlp_pkg::REG_ACTIVE_FLOOR: floor_q    <= cfg_data;
				fdlp_pkg::REG_CUR_MAX:      cmax_q     <= cfg_data;
				fdlp_pkg::REG_MIN_SPEED:    mins_q     <= cfg_data;
				fdlp_pkg::REG_MAX_SPEED:    maxs_q     <= cfg_data;
				fdlp_pkg::REG_INVERT:       invert_q   <= cfg_data[0];
				fdlp_pkg::REG_FEEDVOLT:     feedvolt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	// shared divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= fdlp_pkg::PH_RESCALE;
		end else if (div_load) begin
			cnt_q <= '0;
			priority case (state_q)
				fdlp_pkg::ST_RESCALE: phase_q <= fdlp_pkg::PH_RESCALE;
				fdlp_pkg::ST_PULSE:   phase_q <= fdlp_pkg::PH_PULSE;
				default:              phase_q <= fdlp_pkg::PH_TARGET;
			endcase
		end else if (state_q == fdlp_pkg::ST_DIV) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			quo_q <= product;
			rem_q <= '0;
			den_q <= den_d;
		end else if (state_q == fdlp_pkg::ST_DIV) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	// request capture and speed path
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pct_q <= (s_tdata[PCT_W-1:0] > fdlp_pkg::PCT_FULL) ?
				fdlp_pkg::PCT_FULL : s_tdata[PCT_W-1:0];
			fb_q  <= s_tdata[PCT_W +: LVL_W];
		end
		priority case (state_q)
			fdlp_pkg::ST_PULSE:  spd_q <= quo7;
			fdlp_pkg::ST_GATE:   spd_q <= ({{(LVL_W-1){1'b0}}, timer_q} < quo_q) ? mins_sat : '0;
			fdlp_pkg::ST_INVERT: spd_q <= spd_inv;
			default: ;
		endcase
	end

	// block state, duty and kick start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q      <= '0;
			target_q     <= '0;
			drive_q      <= '0;
			last_speed_q <= '0;
			duty_q       <= '0;
			boost_q      <= 1'b0;
			kick_q       <= 1'b0;
		end else begin
			unique case (state_q)
				fdlp_pkg::ST_IDLE:
					if (s_tvalid) boost_q <= 1'b0;
				fdlp_pkg::ST_PULSE:
					if (quo7 >= mins_sat) timer_q <= '0;
				fdlp_pkg::ST_GATE:
					timer_q <= (timer_q + LVL_W'(1) > STEPS_LAST) ? '0 : timer_q + LVL_W'(1);
				fdlp_pkg::ST_INVERT:
					last_speed_q <= spd_inv;
				fdlp_pkg::ST_SCALE: begin
					if (spd_q == '0) target_q <= '0;
					kick_q <= (target_q == '0);
				end
				fdlp_pkg::ST_TARGET: begin
					target_q <= quo_q[LVL_W-1:0] + (feedvolt_q ? fdlp_pkg::TGT_FV_LOW : '0);
					if (kick_q) begin
						drive_q <= fdlp_pkg::BOOST_PRESET;
						duty_q  <= fdlp_pkg::BOOST_DUTY;
						boost_q <= 1'b1;
					end
				end
				fdlp_pkg::ST_TRIM: begin
					drive_q <= trim_lvl;
					duty_q  <= trim_lvl;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == fdlp_pkg::ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fdlp_pkg::ST_DONE && out_free) begin
			m_tdata_q <= {1'b0, last_speed_q, duty_q};
			m_tuser_q <= boost_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks
	a_timer_range: assert property (@(posedge clk) disable iff (!arst_n)
		timer_q < LVL_W'(PERIOD_STEPS))
		else $error("long pulse timer out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdlp_pkg::ST_DIV) |-> (den_q != '0))
		else $error("divider running with zero divisor");

	a_boost_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[LVL_W-1:0] == fdlp_pkg::BOOST_DUTY))
		else $error("kick start result without full duty");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while a request is in flight");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the long-period pwm fan drive core: a queue-fed
// stream driver, a scoreboard monitor and a per-request predictor of duty,
// speed and kick start, run over directed and randomized register settings
// ----------------------------------------------------------------------------
module tb_top;
	import fdlp_pkg::*;

	localparam int PULSE_STEPS    = PERIOD_STEPS_DEF;
	localparam int GAP_PCT        = 25;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 60;
	localparam int STALL_LIMIT    = 5000;
	localparam int RAND_PHASES    = 10;
	localparam int RAND_PER_PHASE = 58;
	localparam logic [IDX_W-1:0] REG_IDX_TOP = '1;

	// one request and one result as the bench sees them
	typedef struct packed {
		logic             req;
		logic [PCT_W-1:0] pct;
		logic [LVL_W-1:0] fb;
	} fan_req_t;

	typedef struct packed {
		logic [LVL_W-1:0] duty;
		logic [PCT_W-1:0] speed;
		logic             boost;
	} fan_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [PCT_W-1:0]     cfg_data = '0;

	fan_req_t pending_reqs[$];
	fan_out_t predicted_outputs[$];
	fan_req_t drv_cur;
	int       queued_cnt = 0;
	int       accepted_cnt = 0;
	int       mismatch_cnt = 0;
	int       idle_cycles = 0;
	int       hold_cnt = 0;
	logic     hold_done = 1'b0;
	logic     tx_no_gap = 1'b0;
	logic     rx_no_stall = 1'b0;
	logic     rx_hold_arm = 1'b0;

	// predictor copy of registers and state, at reset values
	logic [PCT_W-1:0] reg_floor    = '0;
	logic [PCT_W-1:0] reg_cmax     = PCT_FULL;
	logic [PCT_W-1:0] reg_mins     = MIN_SPEED_RST;
	logic [PCT_W-1:0] reg_maxs     = PCT_FULL;
	logic             reg_invert   = 1'b0;
	logic             reg_feedvolt = 1'b0;
	logic [LVL_W-1:0] pulse_timer  = '0;
	logic [LVL_W-1:0] blower_tgt   = '0;
	logic [LVL_W-1:0] drive_lvl    = '0;
	logic [PCT_W-1:0] last_spd     = '0;

	fan_drive_long_pwm_feedback_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int sat_pct(logic [PCT_W-1:0] v);
		return (v > PCT_FULL) ? int'(PCT_FULL) : int'(v);
	endfunction

	// drive trim toward the target by half the feedback error
	function automatic void trim_drive(logic [LVL_W-1:0] fb);
		int err;
		int nv;
		if (blower_tgt != 0 && reg_feedvolt) begin
			err = int'(blower_tgt) - int'(fb);
			nv = int'(drive_lvl) + err / 2;
			if (nv < 1) nv = 1;
			if (nv > 255) nv = 255;
			drive_lvl = LVL_W'(nv);
		end else begin
			drive_lvl = blower_tgt;
		end
	endfunction

	function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [PCT_W-1:0] val);
		case (idx)
			REG_ACTIVE_FLOOR: reg_floor = val;
			REG_CUR_MAX:      reg_cmax = val;
			REG_MIN_SPEED:    reg_mins = val;
			REG_MAX_SPEED:    reg_maxs = val;
			REG_INVERT:       reg_invert = val[0];
			REG_FEEDVOLT:     reg_feedvolt = val[0];
			default: ;
		endcase
	endfunction

	// expected duty, speed and kick flag for one request
	function automatic fan_out_t fan_stage_step(fan_req_t r);
		fan_out_t o;
		int pct;
		int flr;
		int cmax;
		int mins;
		int maxs;
		int spd;
		logic kick;
		logic [LVL_W-1:0] duty;
		pct = sat_pct(r.pct);
		o.boost = 1'b0;
		if (!r.req) begin
			trim_drive(r.fb);
			duty = drive_lvl;
		end else begin
			flr = (reg_floor > FLOOR_MAX) ? int'(FLOOR_MAX) : int'(reg_floor);
			cmax = sat_pct(reg_cmax);
			mins = sat_pct(reg_mins);
			maxs = sat_pct(reg_maxs);
			if (pct < flr) spd = 0;
			else spd = (pct - flr) * cmax / (100 - flr);
			// slow on/off pulsing below the minimum speed
			if (spd >= mins) begin
				pulse_timer = '0;
			end else begin
				if (PULSE_STEPS * spd / mins > int'(pulse_timer)) spd = mins;
				else spd = 0;
				pulse_timer = pulse_timer + 1'b1;
				if (int'(pulse_timer) > PULSE_STEPS - 1) pulse_timer = '0;
			end
			if (reg_invert) spd = (maxs > spd) ? maxs - spd : 0;
			last_spd = PCT_W'(spd);
			if (spd == 0) begin
				blower_tgt = '0;
				trim_drive(r.fb);
				duty = drive_lvl;
			end else begin
				kick = (blower_tgt == 0);
				if (reg_feedvolt)
					blower_tgt = LVL_W'(int'(TGT_FV_SPAN) * spd / 100 + int'(TGT_FV_LOW));
				else
					blower_tgt = LVL_W'(int'(TGT_FULL) * spd / 100);
				// leaving zero gives one full-on kick start period
				if (kick) begin
					drive_lvl = BOOST_PRESET;
					duty = BOOST_DUTY;
					o.boost = 1'b1;
				end else begin
					trim_drive(r.fb);
					duty = drive_lvl;
				end
			end
		end
		o.duty = duty;
		o.speed = last_spd;
		return o;
	endfunction

	// request driver, fed from the pending queue
	always @(posedge clk or negedge arst_n) begin : req_driver
		fan_req_t nxt;
		fan_out_t pred;
		logic load;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pred = fan_stage_step(drv_cur);
				predicted_outputs = {predicted_outputs, pred};
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				load = (pending_reqs.size() != 0) &&
					(tx_no_gap || $urandom_range(0, 99) >= GAP_PCT);
				s_tvalid <= load;
				if (load) begin
					nxt = pending_reqs.pop_front();
					drv_cur = nxt;
					s_tdata <= {1'b0, nxt.fb, nxt.pct};
					s_tuser <= nxt.req;
				end
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (rx_hold_arm && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
		end else begin
			m_tready <= rx_no_stall || ($urandom_range(0, 99) >= GAP_PCT);
		end
	end

	// scoreboard: compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_monitor
		fan_out_t exp_o;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_outputs.size() == 0) begin
				$display("%0t unexpected result duty %0d speed %0d boost %0d", $time,
					m_tdata[7:0], m_tdata[14:8], m_tuser);
				mismatch_cnt++;
			end else begin
				exp_o = predicted_outputs.pop_front();
				if (m_tdata[7:0] !== exp_o.duty) begin
					$display("%0t pwm_duty mismatch expected %0d actual %0d", $time,
						exp_o.duty, m_tdata[7:0]);
					mismatch_cnt++;
				end
				if (m_tdata[14:8] !== exp_o.speed) begin
					$display("%0t fan_speed mismatch expected %0d actual %0d", $time,
						exp_o.speed, m_tdata[14:8]);
					mismatch_cnt++;
				end
				if (m_tuser !== exp_o.boost) begin
					$display("%0t boost mismatch expected %0d actual %0d", $time,
						exp_o.boost, m_tuser);
					mismatch_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t watchdog: no progress, %0d results outstanding", $time,
					predicted_outputs.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic queue_req(logic req, logic [PCT_W-1:0] pct, logic [LVL_W-1:0] fb);
		fan_req_t r;
		r.req = req;
		r.pct = pct;
		r.fb = fb;
		pending_reqs = {pending_reqs, r};
		queued_cnt++;
	endtask

	// wait until every request is in and every result is out
	task automatic wait_drain();
		while (accepted_cnt != queued_cnt || predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write transaction, entered at a rising edge
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [PCT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
	endtask

	task automatic program_regs(logic [PCT_W-1:0] flr, logic [PCT_W-1:0] cmax,
		logic [PCT_W-1:0] mins, logic [PCT_W-1:0] maxs,
		logic [PCT_W-1:0] inv, logic [PCT_W-1:0] fv);
		write_reg(REG_ACTIVE_FLOOR, flr);
		write_reg(REG_CUR_MAX, cmax);
		write_reg(REG_MIN_SPEED, mins);
		write_reg(REG_MAX_SPEED, maxs);
		write_reg(REG_INVERT, inv);
		write_reg(REG_FEEDVOLT, fv);
		// unmapped index, must be dropped
		write_reg(IDX_W'($urandom_range(REG_FEEDVOLT + 1, REG_IDX_TOP)),
			PCT_W'($urandom_range(0, 127)));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PCT_W-1:0] pick_cfg(int lo, int hi);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return PCT_FULL;
			2: return FLOOR_MAX;
			3: return '1;
			default: return PCT_W'($urandom_range(lo, hi));
		endcase
	endfunction

	initial begin : stimulus
		int n;
		int k;
		logic [PCT_W-1:0] pct;
		logic [LVL_W-1:0] fb;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: trim before any commit, kick, saturation, pulse train
		queue_req(1'b0, 7'd0, 8'd255);
		queue_req(1'b1, 7'd0, 8'd0);
		queue_req(1'b1, PCT_FULL, 8'd255);
		queue_req(1'b1, PCT_FULL, 8'd0);
		queue_req(1'b1, '1, 8'd128);
		queue_req(1'b0, '1, 8'd0);
		repeat (6) queue_req(1'b1, 7'd5, 8'd40);
		queue_req(1'b1, 7'd50, 8'd77);
		wait_drain();

		// feedback mode: kick preset, then trims into both clamps
		program_regs(7'd20, PCT_FULL, 7'd0, PCT_FULL, 7'd0, 7'd1);
		queue_req(1'b1, 7'd0, 8'd0);
		queue_req(1'b1, PCT_FULL, 8'd0);
		queue_req(1'b0, 7'd0, 8'd0);
		queue_req(1'b0, 7'd0, 8'd0);
		queue_req(1'b1, 7'd21, 8'd255);
		repeat (3) queue_req(1'b0, 7'd0, 8'd255);
		wait_drain();

		// saturated registers with invert
		program_regs('1, '1, '1, '1, 7'd1, 7'd0);
		queue_req(1'b1, FLOOR_MAX, 8'd10);
		queue_req(1'b1, PCT_FULL, 8'd200);
		queue_req(1'b1, 7'd0, 8'd0);
		wait_drain();

		// randomized settings, mostly commits followed by a few trims
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			program_regs(pick_cfg(0, 60), pick_cfg(30, 100), pick_cfg(0, 40),
				pick_cfg(50, 100), PCT_W'($urandom_range(0, 127)),
				PCT_W'($urandom_range(0, 127)));
			tx_no_gap = (ph == 3);
			rx_no_stall = (ph == 3);
			rx_hold_arm = (ph == 6);
			n = 0;
			while (n < RAND_PER_PHASE) begin
				case ($urandom_range(0, 3))
					0: pct = PCT_W'($urandom_range(0, 20));
					1: pct = PCT_W'($urandom_range(0, 127));
					default: pct = PCT_W'($urandom_range(0, 100));
				endcase
				fb = ($urandom_range(0, 4) == 0) ? {LVL_W{$urandom_range(0, 1) == 1}}
					: LVL_W'($urandom_range(0, 255));
				if ($urandom_range(0, 9) < 8) begin
					queue_req(1'b1, pct, fb);
					n++;
					k = $urandom_range(0, 4);
					repeat (k) begin
						queue_req(1'b0, PCT_W'($urandom_range(0, 127)),
							LVL_W'($urandom_range(0, 255)));
						n++;
					end
				end else begin
					queue_req($urandom_range(0, 1) == 1, PCT_W'($urandom_range(0, 127)), fb);
					n++;
				end
			end
			wait_drain();
			tx_no_gap = 1'b0;
			rx_no_stall = 1'b0;
		end

		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
